### rtl/scme_pkg.sv
// ----------------------------------------------------------------------------
// scme_pkg
// Shared types, codes and helpers of the string compare and match engine.
// ----------------------------------------------------------------------------
package scme_pkg;

	localparam logic REQ_PATTERN = 1'b0;
	localparam logic REQ_SUBJECT = 1'b1;

	localparam logic [1:0] MODE_COMPARE  = 2'd0;
	localparam logic [1:0] MODE_CONTAINS = 2'd1;
	localparam logic [1:0] MODE_STARTS   = 2'd2;
	localparam logic [1:0] MODE_ENDS     = 2'd3;

	localparam logic CFG_MATCH_MODE  = 1'b0;
	localparam logic CFG_IGNORE_CASE = 1'b1;

	localparam logic signed [1:0] ORDER_LESS    = -2'sd1;
	localparam logic signed [1:0] ORDER_EQUAL   = 2'sd0;
	localparam logic signed [1:0] ORDER_GREATER = 2'sd1;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	typedef struct packed {
		logic       is_subject;
		logic       has_byte;
		logic       ends;
		logic [7:0] byte_raw;
		logic [7:0] byte_fold;
	} cmd_t;

	typedef struct packed {
		logic signed [1:0] order;
		logic              matched;
		logic              pattern_too_long;
	} res_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
		logic [7:0] r;
		r = c;
		if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
			r = c + CASE_OFFSET;
		return r;
	endfunction

endpackage

### rtl/scme_fifo.sv
// ----------------------------------------------------------------------------
// scme_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module scme_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/scme_front.sv
// ----------------------------------------------------------------------------
// scme_front
// Accepts input items, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module scme_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ignore_case,
	input  logic          push,
	output logic          full,
	input  logic          req_type,
	input  logic [7:0]    byte_value,
	input  logic          is_last,
	input  logic          is_empty,
	output scme_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_pop
);
	import scme_pkg::*;

	cmd_t                 cmd_in;
	logic [$bits(cmd_t)-1:0] cmd_bits;
	logic                 cmd_empty;

	always_comb begin
		cmd_in.is_subject = (req_type == REQ_SUBJECT);
		cmd_in.has_byte   = !is_empty;
		cmd_in.ends       = is_last || is_empty;
		cmd_in.byte_raw   = byte_value;
		cmd_in.byte_fold  = fold_byte(byte_value, ignore_case);
	end

	scme_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rd_data(cmd_bits),
		.empty  (cmd_empty)
	);

	assign cmd       = cmd_t'(cmd_bits);
	assign cmd_valid = !cmd_empty;

endmodule

### rtl/scme_exec.sv
// ----------------------------------------------------------------------------
// scme_exec
// Pattern store, shift-and match vector, compare state and result queue.
// ----------------------------------------------------------------------------
module scme_exec #(
	parameter int PATTERN_MAX = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            match_mode,
	input  logic                  ignore_case,
	input  scme_pkg::cmd_t        cmd,
	input  logic                  cmd_valid,
	output logic                  cmd_pop,
	output logic                  empty,
	input  logic                  pop,
	output logic signed [1:0]     order,
	output logic                  matched,
	output logic                  pattern_too_long
);
	import scme_pkg::*;

	localparam int IW = $clog2(PATTERN_MAX);
	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int PW = $clog2(PATTERN_MAX + 2);

	logic [7:0]             store_q [PATTERN_MAX];
	logic [LW-1:0]          len_q;
	logic                   ovf_q, restart_q;
	logic [PW-1:0]          pos_q;
	logic [PATTERN_MAX-1:0] mv_q;
	logic                   contains_q, prefix_q, decided_q;
	logic signed [1:0]      sign_q;

	logic [PATTERN_MAX-1:0] bmask, mv_upd, mv_n;
	logic [LW-1:0]          lm1, len_eff;
	logic                   ovf_eff, pos_lt, eq_at, last_upd;
	logic [7:0]             p_at;
	logic [PW-1:0]          pos_n;
	logic                   contains_n, prefix_n, decided_n;
	logic signed [1:0]      sign_n;
	logic                   ends_bit, hit, produces, go, res_full;
	res_t                   res_in, res_out;
	logic [$bits(res_t)-1:0] res_bits;

	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++)
			bmask[j] = (LW'(j) < len_q) &&
				(fold_byte(store_q[j], ignore_case) == cmd.byte_fold);
	end

	assign mv_upd   = {mv_q[PATTERN_MAX-2:0], 1'b1} & bmask;
	assign lm1      = len_q - LW'(1);
	assign last_upd = (len_q != '0) && mv_upd[lm1[IW-1:0]];
	assign pos_lt   = (PW'(len_q) > pos_q);
	assign p_at     = store_q[pos_q[IW-1:0]];
	assign eq_at    = bmask[pos_q[IW-1:0]];
	assign len_eff  = restart_q ? '0 : len_q;
	assign ovf_eff  = restart_q ? 1'b0 : ovf_q;

	// subject state after this item's byte, if it has one
	always_comb begin
		mv_n       = mv_q;
		contains_n = contains_q;
		prefix_n   = prefix_q;
		decided_n  = decided_q;
		sign_n     = sign_q;
		pos_n      = pos_q;
		if (cmd.has_byte) begin
			mv_n       = mv_upd;
			contains_n = contains_q | last_upd;
			if (pos_lt) begin
				if (!eq_at) begin
					prefix_n = 1'b0;
					if (!decided_q) begin
						decided_n = 1'b1;
						sign_n    = (cmd.byte_raw < p_at) ? ORDER_LESS : ORDER_GREATER;
					end
				end
			end else if (!decided_q) begin
				decided_n = 1'b1;
				sign_n    = ORDER_GREATER;
			end
			if (pos_q <= PW'(PATTERN_MAX))
				pos_n = pos_q + 1'b1;
		end
	end

	always_comb begin
		ends_bit = (len_q == '0) || mv_n[lm1[IW-1:0]];
		unique case (match_mode)
			MODE_CONTAINS: hit = (len_q == '0) || contains_n;
			MODE_STARTS:   hit = prefix_n && (pos_n >= PW'(len_q));
			MODE_ENDS:     hit = ends_bit;
			default:       hit = 1'b0;
		endcase
		if (match_mode != MODE_COMPARE)
			res_in.order = ORDER_EQUAL;
		else if (decided_n)
			res_in.order = sign_n;
		else
			res_in.order = (pos_n == PW'(len_q)) ? ORDER_EQUAL : ORDER_LESS;
		res_in.matched          = hit;
		res_in.pattern_too_long = ovf_q;
	end

	assign produces = cmd.is_subject && cmd.ends;
	assign go       = cmd_valid && !(produces && res_full);
	assign cmd_pop  = go;

	always_ff @(posedge clk) begin
		if (go && !cmd.is_subject && cmd.has_byte && len_eff < LW'(PATTERN_MAX))
			store_q[len_eff[IW-1:0]] <= cmd.byte_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			ovf_q      <= 1'b0;
			restart_q  <= 1'b1;
			pos_q      <= '0;
			mv_q       <= '0;
			contains_q <= 1'b0;
			prefix_q   <= 1'b1;
			decided_q  <= 1'b0;
			sign_q     <= ORDER_EQUAL;
		end else if (go) begin
			if (!cmd.is_subject || cmd.ends) begin
				pos_q      <= '0;
				mv_q       <= '0;
				contains_q <= 1'b0;
				prefix_q   <= 1'b1;
				decided_q  <= 1'b0;
				sign_q     <= ORDER_EQUAL;
			end else begin
				pos_q      <= pos_n;
				mv_q       <= mv_n;
				contains_q <= contains_n;
				prefix_q   <= prefix_n;
				decided_q  <= decided_n;
				sign_q     <= sign_n;
			end
			if (cmd.is_subject) begin
				restart_q <= 1'b1;
			end else begin
				restart_q <= cmd.ends;
				len_q     <= len_eff;
				ovf_q     <= ovf_eff;
				if (cmd.has_byte) begin
					if (len_eff < LW'(PATTERN_MAX))
						len_q <= len_eff + 1'b1;
					else
						ovf_q <= 1'b1;
				end
			end
		end
	end

	scme_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (go && produces),
		.wr_data(res_in),
		.full   (res_full),
		.pop    (pop),
		.rd_data(res_bits),
		.empty  (empty)
	);

	assign res_out          = res_t'(res_bits);
	assign order            = res_out.order;
	assign matched          = res_out.matched;
	assign pattern_too_long = res_out.pattern_too_long;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(PATTERN_MAX))
		else $error("pattern length beyond capacity");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(PATTERN_MAX + 1))
		else $error("subject position beyond saturation");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == LW'(PATTERN_MAX))
		else $error("overflow flagged on a pattern that is not full");

	a_sign_decided: assert property (@(posedge clk) disable iff (!arst_n)
		!decided_q |-> sign_q == ORDER_EQUAL)
		else $error("order sign set before a difference was seen");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && produces && res_full |-> !cmd_pop)
		else $error("verdict transfer while result queue full");

endmodule

### rtl/string_compare_and_match_engine.sv
// ----------------------------------------------------------------------------
// string_compare_and_match_engine
// Loads a pattern byte by byte, then streams a subject and gives one verdict
// per subject: lexicographic compare, contains, starts-with or ends-with.
//
//   channel   signals                                   transfer when
//   input     push full req_type byte_value is_last     push && !full
//             is_empty
//   result    empty pop order matched pattern_too_long  pop && !empty
//   config    cfg_we cfg_index cfg_data                 cfg_we
//
// One item per cycle sustained while no verdict waits on a full result queue.
// The last item leaves the command queue; its verdict is registered in the result queue.
// A 4-entry command queue and a 2-entry result queue decouple the two sides;
// with pop held low, full rises once both queues have filled.
// Reset is asynchronous; no clearing pass, the block is ready right after it.
// ----------------------------------------------------------------------------
module string_compare_and_match_engine #(
	parameter int PATTERN_MAX = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              req_type,
	input  logic [7:0]        byte_value,
	input  logic              is_last,
	input  logic              is_empty,
	output logic              empty,
	input  logic              pop,
	output logic signed [1:0] order,
	output logic              matched,
	output logic              pattern_too_long,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [1:0]        cfg_data
);
	import scme_pkg::*;

	logic [1:0] match_mode_q;
	logic       ignore_case_q;
	cmd_t       cmd;
	logic       cmd_valid, cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_mode_q  <= MODE_COMPARE;
			ignore_case_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MATCH_MODE:  match_mode_q  <= cfg_data;
				CFG_IGNORE_CASE: ignore_case_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	scme_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ignore_case(ignore_case_q),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.byte_value (byte_value),
		.is_last    (is_last),
		.is_empty   (is_empty),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop)
	);

	scme_exec #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_exec (
		.clk             (clk),
		.arst_n          (arst_n),
		.match_mode      (match_mode_q),
		.ignore_case     (ignore_case_q),
		.cmd             (cmd),
		.cmd_valid       (cmd_valid),
		.cmd_pop         (cmd_pop),
		.empty           (empty),
		.pop             (pop),
		.order           (order),
		.matched         (matched),
		.pattern_too_long(pattern_too_long)
	);

endmodule
